FILE: design/lfc_pkg.sv
// Shared types and constants of the lift floor controller.
package lfc_pkg;

   localparam int FLOORS      = 4;
   localparam int BUTTON_BITS = 4;
   localparam int FLOOR_W     = 3;
   localparam int FLOOR_LIMIT = (FLOORS < BUTTON_BITS) ? FLOORS : BUTTON_BITS;

   typedef logic [FLOOR_W-1:0] floor_type;

   typedef struct packed {
      floor_type current_floor;
      floor_type target_floor;
      logic      in_motion;
      logic      going_up;
      logic      first_magnet_seen;
      logic      magnet_prev;
   } state_type;

   typedef struct packed {
      logic                   door_open;
      logic [BUTTON_BITS-1:0] call_buttons;
      logic                   magnet_active;
   } req_type;

   typedef struct packed {
      logic      motor_up;
      logic      motor_down;
      logic      brake_engaged;
      floor_type floor_now;
      logic      moving;
      logic      door_blocked;
      logic      status_send;
   } rsp_type;

   localparam state_type STATE_RESET = '{
      current_floor:     floor_type'(1),
      target_floor:      floor_type'(1),
      in_motion:         1'b0,
      going_up:          1'b0,
      first_magnet_seen: 1'b0,
      magnet_prev:       1'b1
   };

endpackage

FILE: design/lfc_req_if.sv
// Sample tick channel: door, call buttons and magnet sensor.
interface lfc_req_if;
   logic       valid;
   logic       ready;
   logic       door_open;
   logic [3:0] call_buttons;
   logic       magnet_active;

   modport source (output valid, output door_open, output call_buttons,
                   output magnet_active, input ready);
   modport sink (input valid, input door_open, input call_buttons,
                 input magnet_active, output ready);
endinterface

FILE: design/lfc_rsp_if.sv
// Result channel: motor, brake, floor and status outputs.
interface lfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       motor_up;
   logic       motor_down;
   logic       brake_engaged;
   logic [2:0] floor_now;
   logic       moving;
   logic       door_blocked;
   logic       status_send;

   modport source (output valid, output motor_up, output motor_down,
                   output brake_engaged, output floor_now, output moving,
                   output door_blocked, output status_send, input ready);
   modport sink (input valid, input motor_up, input motor_down,
                 input brake_engaged, input floor_now, input moving,
                 input door_blocked, input status_send, output ready);
endinterface

FILE: design/lfc_step.sv
// Next-state and result logic for one sample tick.
module lfc_step (
   input  lfc_pkg::state_type state_cur,
   input  lfc_pkg::req_type   item,
   output lfc_pkg::state_type state_nxt,
   output lfc_pkg::rsp_type   result
);
   import lfc_pkg::*;

   logic      found;
   floor_type wanted;
   floor_type floor_up;
   floor_type floor_down;
   logic      edge_rise;
   logic      send;

   always_comb begin
      found  = 1'b0;
      wanted = '0;
      for (int i = 0; i < BUTTON_BITS; i++) begin
         if ((i < FLOOR_LIMIT) && item.call_buttons[i] &&
             (floor_type'(i + 1) != state_cur.current_floor)) begin
            found  = 1'b1;
            wanted = floor_type'(i + 1);
         end
      end
   end

   assign floor_up   = (int'(state_cur.current_floor) < FLOORS) ?
                       state_cur.current_floor + floor_type'(1) : state_cur.current_floor;
   assign floor_down = (state_cur.current_floor > floor_type'(1)) ?
                       state_cur.current_floor - floor_type'(1) : state_cur.current_floor;
   assign edge_rise  = item.magnet_active && !state_cur.magnet_prev;

   always_comb begin
      state_nxt = state_cur;
      send      = 1'b0;
      if (item.door_open) begin
         if (state_cur.in_motion) begin
            state_nxt.in_motion         = 1'b0;
            state_nxt.first_magnet_seen = 1'b0;
            send                        = 1'b1;
         end
      end else begin
         if (!state_cur.in_motion && found) begin
            state_nxt.target_floor      = wanted;
            state_nxt.going_up          = wanted > state_cur.current_floor;
            state_nxt.in_motion         = 1'b1;
            state_nxt.first_magnet_seen = 1'b0;
         end
         if (state_nxt.in_motion) begin
            if (edge_rise) begin
               if (!state_nxt.first_magnet_seen) begin
                  state_nxt.first_magnet_seen = 1'b1;
               end else begin
                  state_nxt.current_floor     = state_nxt.going_up ? floor_up : floor_down;
                  state_nxt.first_magnet_seen = 1'b0;
                  send                        = 1'b1;
                  if (state_nxt.current_floor == state_nxt.target_floor) begin
                     state_nxt.in_motion = 1'b0;
                  end
               end
            end
            state_nxt.magnet_prev = item.magnet_active;
         end
      end
   end

   always_comb begin
      result.motor_up      = state_nxt.in_motion && state_nxt.going_up;
      result.motor_down    = state_nxt.in_motion && !state_nxt.going_up;
      result.brake_engaged = !state_nxt.in_motion;
      result.floor_now     = state_nxt.current_floor;
      result.moving        = state_nxt.in_motion;
      result.door_blocked  = item.door_open;
      result.status_send   = send;
   end

endmodule

FILE: design/lift_floor_controller_core.sv
// Lift floor controller top level: input register, tick update, result register.
// An accepted sample tick passes through the input register, then the result register.
// Throughput: one item per cycle; input register and result register both advance
// whenever the result register is empty or its item is being taken.
// Reset (synchronous): floor 1, target 1, idle, magnet history high, both registers empty.
module lift_floor_controller_core (
   input logic       clock,
   input logic       reset,
   lfc_req_if.sink   req_port,
   lfc_rsp_if.source rsp_port
);
   import lfc_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_item_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_item_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_result;
   logic      advance;
   logic      out_free;

   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_port.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_port.valid || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_port.ready);

   lfc_step u_step (
      .state_cur (state_ff),
      .item      (in_item_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_port.ready) begin
            in_valid_ff <= in_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_item_ff.door_open     <= req_port.door_open;
         in_item_ff.call_buttons  <= req_port.call_buttons;
         in_item_ff.magnet_active <= req_port.magnet_active;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.motor_up      = rsp_item_ff.motor_up;
   assign rsp_port.motor_down    = rsp_item_ff.motor_down;
   assign rsp_port.brake_engaged = rsp_item_ff.brake_engaged;
   assign rsp_port.floor_now     = rsp_item_ff.floor_now;
   assign rsp_port.moving        = rsp_item_ff.moving;
   assign rsp_port.door_blocked  = rsp_item_ff.door_blocked;
   assign rsp_port.status_send   = rsp_item_ff.status_send;

   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.current_floor >= floor_type'(1)) &&
      (state_ff.current_floor <= floor_type'(FLOOR_LIMIT)))
      else $error("floor out of range");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an item");

   a_door_stops: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.door_open) |=> !state_ff.in_motion)
      else $error("trip continued with door open");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((state_ff.current_floor == $past(state_ff.current_floor)) ||
                   (state_ff.current_floor == $past(state_ff.current_floor) + floor_type'(1)) ||
                   (state_ff.current_floor == $past(state_ff.current_floor) - floor_type'(1))))
      else $error("floor moved by more than one");

   a_result_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_port.ready) |=> rsp_valid_ff)
      else $error("result dropped while stalled");

endmodule
